// File: rtl/core/nhtf_pkg.sv
// ----------------------------------------------------------------------------
// nhtf_pkg: shared types and arithmetic helpers for the triangle force block
// Holds Q16.16 widths, saturation and floor-shift helpers and the vertex-index struct.
// ----------------------------------------------------------------------------
`default_nettype none
package nhtf_pkg;

  localparam int unsigned QW       = 32;
  localparam int unsigned MODW     = 31;
  localparam int unsigned IDXW     = 16;
  localparam int unsigned VERTEX_COUNT = 65536;
  localparam int unsigned DIVW     = 33;   // width of the Ic+1 divisor
  localparam int unsigned ALPHAQW  = 49;   // width of 3*mu << 16

  // Register indexes
  localparam logic CFG_SHEAR = 1'b0;
  localparam logic CFG_BULK  = 1'b1;

  localparam logic signed [QW-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [QW-1:0] S32_MIN = 32'sh8000_0000;

  // Saturate a 66-bit signed value to 32 bits
  function automatic logic signed [QW-1:0] sat32(input logic signed [65:0] x);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'(S32_MAX);
    lo = 66'(S32_MIN);
    if (x > hi) return S32_MAX;
    else if (x < lo) return S32_MIN;
    else return x[QW-1:0];
  endfunction

  // Product of two 33-bit signed values, floor-shifted by 16
  function automatic logic signed [65:0] qmul(input logic signed [32:0] a,
                                              input logic signed [32:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b);
    return p >>> 16;
  endfunction

  typedef struct packed {
    logic [IDXW-1:0] va;
    logic [IDXW-1:0] vb;
    logic [IDXW-1:0] vc;
  } idx_t;

endpackage
`default_nettype wire

// File: rtl/core/nhtf_divider.sv
// ----------------------------------------------------------------------------
// nhtf_divider: pipelined unsigned restoring divider
// One quotient bit per stage; one new division may enter each cycle while en_i is high.
// ----------------------------------------------------------------------------
`default_nettype none
module nhtf_divider #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 33
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [NW-1:0] quo_o
);

  logic [NW-1:0] num_q [NW+1];
  logic [DW-1:0] den_q [NW+1];
  logic [DW:0]   rem_q [NW+1];

  assign num_q[0] = num_i;
  assign den_q[0] = den_i;
  assign rem_q[0] = '0;

  // One shift-subtract per stage; quotient bits fill num from the bottom
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW+1:0] trial;
    logic [DW:0]   rem_sh;
    always_comb begin
      rem_sh = {rem_q[k][DW-1:0], num_q[k][NW-1]};
      trial  = {1'b0, rem_sh} - {2'b00, den_q[k]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q[k+1] <= '0;
      end else if (en_i) begin
        if (!trial[DW+1]) begin
          rem_q[k+1] <= trial[DW:0];
          num_q[k+1] <= {num_q[k][NW-2:0], 1'b1};
        end else begin
          rem_q[k+1] <= rem_sh;
          num_q[k+1] <= {num_q[k][NW-2:0], 1'b0};
        end
        den_q[k+1] <= den_q[k];
      end
    end
  end

  assign quo_o = num_q[NW];

endmodule
`default_nettype wire

// File: rtl/core/neo_hookean_triangle_force.sv
// ----------------------------------------------------------------------------
// neo_hookean_triangle_force: stable Neo-Hookean force for one 2D triangle
// Usage: one face word on the slave stream gives one force word on the
// master stream. The slave word carries F, B, area and three vertex indices;
// the master word carries the indices and six Q16.16 force components.
// The user writes mu and lambda through the plain write port while idle;
// the block does not enforce this. Throughput: one word per cycle while
// the output is not stalled. From acceptance to output valid, the 49-stage
// Ic and alpha dividers run side by side, plus seven registers for squares,
// Ic/det, s/alpha, mu/lambda scale, stress, gradient sums and the area scale.
// Stall: the whole pipeline advances only when the output register is
// empty or being taken; s_axis_tready follows that, so nothing is lost.
// Reset: valid bits clear; mu and lambda return to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none
module neo_hookean_triangle_force (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // grad_00..11, rest_inv_00..11 (32 each), area (31), vertex_a/b/c (16), pad 1
  input  wire logic [335:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_vertex_a/b/c (16 each), force_a_x, a_y, b_x, b_y, c_x, c_y (32 each)
  output logic [239:0]      m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_addr_i,
  input  wire logic [30:0]  cfg_wdata_i
);

  localparam int unsigned DPIPE = nhtf_pkg::ALPHAQW; // divider stages

  logic adv;
  logic [nhtf_pkg::MODW-1:0] mu_q, lam_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q  <= 31'd65536;
      lam_q <= 31'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        nhtf_pkg::CFG_SHEAR: mu_q  <= cfg_wdata_i;
        nhtf_pkg::CFG_BULK:  lam_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Unpack
  logic signed [31:0] f00, f01, f10, f11, b00, b01, b10, b11;
  logic [30:0] ar;
  nhtf_pkg::idx_t idx_in;
  assign f00 = s_axis_tdata[31:0];
  assign f01 = s_axis_tdata[63:32];
  assign f10 = s_axis_tdata[95:64];
  assign f11 = s_axis_tdata[127:96];
  assign b00 = s_axis_tdata[159:128];
  assign b01 = s_axis_tdata[191:160];
  assign b10 = s_axis_tdata[223:192];
  assign b11 = s_axis_tdata[255:224];
  assign ar  = s_axis_tdata[286:256];
  assign idx_in.va = s_axis_tdata[287+:nhtf_pkg::IDXW];
  assign idx_in.vb = s_axis_tdata[303+:nhtf_pkg::IDXW];
  assign idx_in.vc = s_axis_tdata[319+:nhtf_pkg::IDXW];

  // Carried payload: F, B, area, indices
  typedef struct packed {
    logic signed [31:0] f00, f01, f10, f11, b00, b01, b10, b11;
    logic [30:0] ar;
    nhtf_pkg::idx_t idx;
  } carry_t;

  carry_t c_in;
  assign c_in = '{f00, f01, f10, f11, b00, b01, b10, b11, ar, idx_in};

  // Stage 1: squares and det products
  logic               v1_q;
  carry_t             c1_q;
  logic signed [65:0] sq0_q, sq1_q, sq2_q, sq3_q, dp0_q, dp1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q  <= c_in;
      sq0_q <= nhtf_pkg::qmul(33'(f00), 33'(f00));
      sq1_q <= nhtf_pkg::qmul(33'(f01), 33'(f01));
      sq2_q <= nhtf_pkg::qmul(33'(f10), 33'(f10));
      sq3_q <= nhtf_pkg::qmul(33'(f11), 33'(f11));
      dp0_q <= 66'(f00) * 66'(f11);
      dp1_q <= 66'(f01) * 66'(f10);
    end
  end

  // Stage 2: Ic and det
  logic               v2_q;
  carry_t             c2_q;
  logic signed [31:0] ic_q, det_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_q  <= c1_q;
      ic_q  <= nhtf_pkg::sat32(sq0_q + sq1_q + sq2_q + sq3_q);
      det_q <= nhtf_pkg::sat32((dp0_q - dp1_q) >>> 16);
    end
  end

  // Dividers: 2^32/(Ic+1) and (3mu<<16)/(4lambda); both DPIPE deep
  logic [DPIPE-1:0] q_ic, q_al;
  logic [nhtf_pkg::DIVW-1:0] ic_den;
  logic [DPIPE-1:0] ic_num;
  assign ic_den = nhtf_pkg::DIVW'(ic_q) + 33'd65536; // Ic >= 0 always
  assign ic_num = DPIPE'(64'h1_0000_0000);

  nhtf_divider #(.NW(DPIPE), .DW(nhtf_pkg::DIVW)) u_div_ic (
    .clk_i, .rst_ni, .en_i(adv), .num_i(ic_num), .den_i(ic_den), .quo_o(q_ic)
  );
  nhtf_divider #(.NW(DPIPE), .DW(nhtf_pkg::DIVW)) u_div_al (
    .clk_i, .rst_ni, .en_i(adv),
    .num_i({DPIPE'(3 * 64'(mu_q)) << 16}),
    .den_i({lam_q, 2'b00}),
    .quo_o(q_al)
  );

  // Delay line alongside the dividers
  logic   vd_q [DPIPE+1];
  carry_t cd_q [DPIPE+1];
  logic signed [31:0] detd_q [DPIPE+1];
  assign vd_q[0] = v2_q;
  assign cd_q[0] = c2_q;
  assign detd_q[0] = det_q;
  for (genvar k = 0; k < DPIPE; k++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vd_q[k+1] <= 1'b0;
      else if (adv) vd_q[k+1] <= vd_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cd_q[k+1]   <= cd_q[k];
        detd_q[k+1] <= detd_q[k];
      end
    end
  end

  // Stage A: s, alpha, det-alpha
  logic               va_q;
  carry_t             ca_q;
  logic signed [31:0] s_q, dl_q;
  logic signed [65:0] alpha_w;
  logic signed [31:0] alpha_s;
  always_comb begin
    alpha_w = 66'sd65536 + ((lam_q == '0) ? 66'sd0 : 66'($unsigned(q_al)));
    alpha_s = nhtf_pkg::sat32(alpha_w);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (adv) va_q <= vd_q[DPIPE];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ca_q <= cd_q[DPIPE];
      s_q  <= 32'sd65536 - 32'(q_ic);
      dl_q <= nhtf_pkg::sat32(66'(detd_q[DPIPE]) - 66'(alpha_s));
    end
  end

  // Stage B: g = lambda*dl, ms = mu*s
  logic               vb_q;
  carry_t             cb_q;
  logic signed [31:0] g_q, ms_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (adv) vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cb_q <= ca_q;
      g_q  <= nhtf_pkg::sat32(nhtf_pkg::qmul(33'({1'b0, lam_q}), 33'(dl_q)));
      ms_q <= nhtf_pkg::sat32(nhtf_pkg::qmul(33'({1'b0, mu_q}), 33'(s_q)));
    end
  end

  // Stage C: P entries and third-vertex weights
  logic               vc_q;
  carry_t             cc_q;
  logic signed [31:0] p00_q, p01_q, p10_q, p11_q, w0_q, w1_q;
  logic signed [32:0] nf10, nf01;
  assign nf10 = -33'(cb_q.f10);
  assign nf01 = -33'(cb_q.f01);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (adv) vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cc_q  <= cb_q;
      p00_q <= nhtf_pkg::sat32(nhtf_pkg::qmul(33'(ms_q), 33'(cb_q.f00))
                             + nhtf_pkg::qmul(33'(g_q), 33'(cb_q.f11)));
      p01_q <= nhtf_pkg::sat32(nhtf_pkg::qmul(33'(ms_q), 33'(cb_q.f01))
                             + nhtf_pkg::qmul(33'(g_q), nf10));
      p10_q <= nhtf_pkg::sat32(nhtf_pkg::qmul(33'(ms_q), 33'(cb_q.f10))
                             + nhtf_pkg::qmul(33'(g_q), nf01));
      p11_q <= nhtf_pkg::sat32(nhtf_pkg::qmul(33'(ms_q), 33'(cb_q.f11))
                             + nhtf_pkg::qmul(33'(g_q), 33'(cb_q.f00)));
      w0_q  <= nhtf_pkg::sat32(-(66'(cb_q.b00) + 66'(cb_q.b10)));
      w1_q  <= nhtf_pkg::sat32(-(66'(cb_q.b01) + 66'(cb_q.b11)));
    end
  end

  // Stage D: gradient sums
  logic               vdd_q;
  nhtf_pkg::idx_t     ie_q;
  logic [30:0]        are_q;
  logic signed [31:0] h_q [6];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vdd_q <= 1'b0;
    else if (adv) vdd_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ie_q   <= cc_q.idx;
      are_q  <= cc_q.ar;
      h_q[0] <= nhtf_pkg::sat32(nhtf_pkg::qmul(33'(cc_q.b00), 33'(p00_q))
                              + nhtf_pkg::qmul(33'(cc_q.b01), 33'(p01_q)));
      h_q[1] <= nhtf_pkg::sat32(nhtf_pkg::qmul(33'(cc_q.b00), 33'(p10_q))
                              + nhtf_pkg::qmul(33'(cc_q.b01), 33'(p11_q)));
      h_q[2] <= nhtf_pkg::sat32(nhtf_pkg::qmul(33'(cc_q.b10), 33'(p00_q))
                              + nhtf_pkg::qmul(33'(cc_q.b11), 33'(p01_q)));
      h_q[3] <= nhtf_pkg::sat32(nhtf_pkg::qmul(33'(cc_q.b10), 33'(p10_q))
                              + nhtf_pkg::qmul(33'(cc_q.b11), 33'(p11_q)));
      h_q[4] <= nhtf_pkg::sat32(nhtf_pkg::qmul(33'(w0_q), 33'(p00_q))
                              + nhtf_pkg::qmul(33'(w1_q), 33'(p01_q)));
      h_q[5] <= nhtf_pkg::sat32(nhtf_pkg::qmul(33'(w0_q), 33'(p10_q))
                              + nhtf_pkg::qmul(33'(w1_q), 33'(p11_q)));
    end
  end

  // Output register: area scale
  logic               vo_q;
  nhtf_pkg::idx_t     io_q;
  logic signed [31:0] fo_q [6];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (adv) vo_q <= vdd_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      io_q <= ie_q;
      for (int k = 0; k < 6; k++) begin
        fo_q[k] <= nhtf_pkg::sat32(nhtf_pkg::qmul(33'({2'b00, are_q}), 33'(h_q[k])));
      end
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {fo_q[5], fo_q[4], fo_q[3], fo_q[2], fo_q[1], fo_q[0],
                          io_q.vc, io_q.vb, io_q.va};

endmodule
`default_nettype wire

// File: rtl/core/nhtf_checker.sv
// ----------------------------------------------------------------------------
// nhtf_checker: port-level checks for the triangle force block
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module nhtf_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [239:0] m_axis_tdata
);

  // A held output word stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");

  // Input ready only when the output can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready not tied to output state");

  // Output valid is low right after reset releases
  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid out of reset");

endmodule

bind neo_hookean_triangle_force nhtf_checker u_nhtf_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
